[rtl/assert_macros.svh]
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define EVS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define EVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/evs_pkg.sv]
package evs_pkg;

  localparam int unsigned ONE_Q16 = 32'h0001_0000;

  // strategy codes
  localparam logic [1:0] MODE_DANTZIG = 2'd0;
  localparam logic [1:0] MODE_STEEP   = 2'd1;
  localparam logic [1:0] MODE_BLAND   = 2'd2;
  localparam logic [1:0] MODE_DEVEX   = 2'd3;

  // variable status codes
  localparam logic [1:0] VS_BASIC = 2'd0;
  localparam logic [1:0] VS_LOWER = 2'd1;
  localparam logic [1:0] VS_UPPER = 2'd2;
  localparam logic [1:0] VS_FREE  = 2'd3;

  // configuration register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_TOL  = 1'b1;

  // multiplier step codes
  localparam logic [2:0] MS_NONE = 3'd0;
  localparam logic [2:0] MS_SQ   = 3'd1;
  localparam logic [2:0] MS_TT   = 3'd2;
  localparam logic [2:0] MS_L0   = 3'd3;
  localparam logic [2:0] MS_L1   = 3'd4;
  localparam logic [2:0] MS_R0   = 3'd5;
  localparam logic [2:0] MS_R1   = 3'd6;

  typedef struct packed {
    logic       load;
    logic [2:0] mstep;
    logic       simple_upd;
    logic       cmp_upd;
    logic       finish;
  } evs_cmd_t;

  typedef struct packed {
    logic elig;
    logic ratio_mode;
    logic last;
    logic out_busy;
  } evs_stat_t;

endpackage

[rtl/entering_variable_select_scan.sv]
// Entering-variable pricing scan.
// Input channel (in_valid/in_stall): one variable per beat, in index order;
// in_last_var marks the final variable of a scan.
// Result channel (out_valid/out_stall): one beat per scan, after the last
// variable: out_entering_index and out_found (0 = optimal, index 0).
// Config port: cfg_we with cfg_index 0 = strategy mode, 1 = tolerance;
// write only while no scan beat is in flight.
// Steps: Dantzig, Bland and ineligible variables go through load, evaluate
// and finish; an eligible variable under steepest edge or Devex also has the
// single 32x32 multiplier stepping through m*m, t*t and two 64x32 products,
// then a compare. The result shows in the cycle after the last beat finishes.
// While the result beat is stalled the block keeps taking input beats; the
// next last beat then waits until the output register empties.
// Reset: mode Devex, tolerance 1, scan state and counter cleared, no result.
module entering_variable_select_scan #(
  parameter int MAX_VARS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_var_state,
  input  logic        in_skip_flag,
  input  logic [31:0] in_reduced_cost,
  input  logic [31:0] in_edge_weight,
  input  logic        in_last_var,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_entering_index,
  output logic        out_found
);
  import evs_pkg::*;

  evs_cmd_t  cmd;
  evs_stat_t stat;

  evs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  evs_dp #(.MAX_VARS(MAX_VARS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_var_state       (in_var_state),
    .in_skip_flag       (in_skip_flag),
    .in_reduced_cost    (in_reduced_cost),
    .in_edge_weight     (in_edge_weight),
    .in_last_var        (in_last_var),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_entering_index (out_entering_index),
    .out_found          (out_found),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule

[rtl/evs_ctrl.sv]
module evs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  evs_pkg::evs_stat_t stat,
  output evs_pkg::evs_cmd_t  cmd
);
  import evs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVAL = 4'd1;
  localparam logic [3:0] S_MSQ  = 4'd2;
  localparam logic [3:0] S_MTT  = 4'd3;
  localparam logic [3:0] S_ML0  = 4'd4;
  localparam logic [3:0] S_ML1  = 4'd5;
  localparam logic [3:0] S_MR0  = 4'd6;
  localparam logic [3:0] S_MR1  = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.mstep = MS_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.elig && stat.ratio_mode) begin
          state_nxt = S_MSQ;
        end else begin
          cmd.simple_upd = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_MSQ: begin cmd.mstep = MS_SQ; state_nxt = S_MTT; end
      S_MTT: begin cmd.mstep = MS_TT; state_nxt = S_ML0; end
      S_ML0: begin cmd.mstep = MS_L0; state_nxt = S_ML1; end
      S_ML1: begin cmd.mstep = MS_L1; state_nxt = S_MR0; end
      S_MR0: begin cmd.mstep = MS_R0; state_nxt = S_MR1; end
      S_MR1: begin cmd.mstep = MS_R1; state_nxt = S_CMP; end
      S_CMP: begin cmd.cmp_upd = 1'b1; state_nxt = S_FIN; end
      S_FIN: begin
        // a last beat waits for the output register to free up
        if (!(stat.last && stat.out_busy)) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[rtl/evs_dp.sv]
module evs_dp #(
  parameter int MAX_VARS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic [1:0]         in_var_state,
  input  logic               in_skip_flag,
  input  logic [31:0]        in_reduced_cost,
  input  logic [31:0]        in_edge_weight,
  input  logic               in_last_var,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_entering_index,
  output logic               out_found,
  input  evs_pkg::evs_cmd_t  cmd,
  output evs_pkg::evs_stat_t stat
);
  import evs_pkg::*;

  localparam int CW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VARS - 1);

  logic [1:0]    mode_r;
  logic [31:0]   tol_r;
  logic [1:0]    st_r;
  logic          skip_r, neg_r, last_r;
  logic [31:0]   mag_r, w_r;
  logic [CW-1:0] cnt_r, bidx_r;
  logic [63:0]   bnum_r, sq_r, bn_r;
  logic [31:0]   bden_r;
  logic          have_r;
  logic [95:0]   lhs_r, rhs_r;
  logic          ov_r, ofound_r;
  logic [15:0]   oidx_r;

  logic          elig, ratio_mode;
  logic [31:0]   wp, bd, mul_a, mul_b;
  logic [63:0]   prod;
  logic [31:0]   mag_in;
  logic [63:0]   dz_ref;

  assign mag_in = in_reduced_cost[31] ? (32'd0 - in_reduced_cost) : in_reduced_cost;

  always_comb begin
    elig = 1'b0;
    if (!skip_r && st_r != VS_BASIC && mag_r > tol_r) begin
      case (st_r)
        VS_LOWER: elig = neg_r;
        VS_UPPER: elig = !neg_r;
        default:  elig = 1'b1;
      endcase
    end
  end

  assign ratio_mode = (mode_r == MODE_STEEP) || (mode_r == MODE_DEVEX);

  always_comb begin
    wp = w_r;
    if (mode_r == MODE_STEEP) begin
      if (w_r == 32'd0) wp = ONE_Q16;
    end else if (w_r < ONE_Q16) begin
      wp = ONE_Q16;
    end
  end

  assign bd     = have_r ? bden_r : ONE_Q16;
  assign dz_ref = have_r ? bnum_r : {32'd0, tol_r};

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd.mstep)
      MS_SQ: begin mul_a = mag_r;        mul_b = mag_r; end
      MS_TT: begin mul_a = tol_r;        mul_b = tol_r; end
      MS_L0: begin mul_a = sq_r[31:0];   mul_b = bd;    end
      MS_L1: begin mul_a = sq_r[63:32];  mul_b = bd;    end
      MS_R0: begin mul_a = bn_r[31:0];   mul_b = wp;    end
      MS_R1: begin mul_a = bn_r[63:32];  mul_b = wp;    end
      default: begin mul_a = 32'd0;      mul_b = 32'd0; end
    endcase
  end

  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DEVEX;
      tol_r  <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_wdata[1:0];
        REG_TOL:  tol_r  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_r   <= in_var_state;
      skip_r <= in_skip_flag;
      neg_r  <= in_reduced_cost[31];
      mag_r  <= mag_in;
      w_r    <= in_edge_weight;
      last_r <= in_last_var;
    end
    case (cmd.mstep)
      MS_SQ: sq_r  <= prod;
      MS_TT: bn_r  <= have_r ? bnum_r : prod;
      MS_L0: lhs_r <= {32'd0, prod};
      MS_L1: lhs_r <= lhs_r + {prod, 32'd0};
      MS_R0: rhs_r <= {32'd0, prod};
      MS_R1: rhs_r <= rhs_r + {prod, 32'd0};
      default: ;
    endcase
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      have_r <= 1'b0;
      bnum_r <= 64'd0;
      bden_r <= ONE_Q16;
      bidx_r <= '0;
    end else if (cmd.finish && last_r) begin
      cnt_r  <= '0;
      have_r <= 1'b0;
      bnum_r <= 64'd0;
      bden_r <= ONE_Q16;
      bidx_r <= '0;
    end else begin
      if (cmd.finish) cnt_r <= (cnt_r == CNT_MAX) ? '0 : cnt_r + 1'b1;
      if (cmd.simple_upd && elig) begin
        if (mode_r == MODE_BLAND) begin
          if (!have_r) begin
            have_r <= 1'b1;
            bidx_r <= cnt_r;
          end
        end else if (mode_r == MODE_DANTZIG) begin
          if ({32'd0, mag_r} > dz_ref) begin
            bnum_r <= {32'd0, mag_r};
            bden_r <= ONE_Q16;
            bidx_r <= cnt_r;
            have_r <= 1'b1;
          end
        end
      end
      if (cmd.cmp_upd && lhs_r > rhs_r) begin
        bnum_r <= sq_r;
        bden_r <= wp;
        bidx_r <= cnt_r;
        have_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.finish && last_r) ov_r <= 1'b1;
    else if (!out_stall) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && last_r) begin
      ofound_r <= have_r;
      oidx_r   <= have_r ? 16'(bidx_r) : 16'd0;
    end
  end

  assign out_valid          = ov_r;
  assign out_found          = ofound_r;
  assign out_entering_index = oidx_r;

  assign stat.elig       = elig;
  assign stat.ratio_mode = ratio_mode;
  assign stat.last       = last_r;
  assign stat.out_busy   = ov_r && out_stall;

endmodule

[rtl/evs_checker.sv]
`include "assert_macros.svh"

module evs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_var,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_entering_index,
  input logic        out_found
);

  // a stalled result beat holds
  `EVS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_entering_index) && $stable(out_found))
  // optimal scans report index zero
  `EVS_ASSERT_IMPL(a_idx_zero, clk, rst_n, out_valid && !out_found,
                   out_entering_index == 16'd0)
  // a taken beat is followed by in_stall high
  `EVS_ASSERT_NEXT(a_busy_after, clk, rst_n, in_valid && !in_stall, in_stall)
  // a result never appears right after a non-last beat
  `EVS_ASSERT_NEXT(a_no_early, clk, rst_n,
                   in_valid && !in_stall && !in_last_var && !out_valid, !out_valid)

endmodule

bind entering_variable_select_scan evs_checker u_evs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_last_var        (in_last_var),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_entering_index (out_entering_index),
  .out_found          (out_found)
);
